@@ src/oda_pkg.sv @@
// Shared constants, types and the quarter-wave sine table builder
// for the octave-down additive oscillator. No dependencies.
package oda_pkg;

   localparam int MAX_HARMONICS       = 16;
   localparam int PHASE_FRACTION_BITS = 32;
   localparam int SINE_TABLE_BITS     = 10;
   localparam int MAX_RUN             = 64;

   localparam int ACC_W          = 48;
   localparam int PHASE_INC_W    = 32;
   localparam int HCOUNT_W       = 5;
   localparam int SAMPLE_W       = 16;
   localparam int SAMPLE_COUNT_W = 7;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [CSR_IDX_W-1:0] IDX_PHASE_INCREMENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_HARMONIC_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] IDX_FALLING_WEIGHTS = 2'd2;

   localparam logic [PHASE_INC_W-1:0] PHASE_INC_RESET = 32'd39409032;
   localparam logic [HCOUNT_W-1:0]    HCOUNT_RESET    = 5'd1;

   localparam int CNT_W       = $clog2(MAX_HARMONICS + 1);
   localparam int RUN_W       = $clog2(MAX_RUN + 1);
   localparam int MAG_W       = 15 + MAX_HARMONICS;
   localparam int SUM_W       = MAG_W + 1;
   localparam int NUM_W       = MAG_W + 2;
   localparam int DEN_W       = MAX_HARMONICS;
   localparam int QUOT_W      = 17;
   localparam int SINE_MAG_W  = 15;
   localparam int QSINE_DEPTH = (1 << (SINE_TABLE_BITS - 2)) + 1;
   localparam int QIDX_W      = SINE_TABLE_BITS - 1;

   localparam logic [63:0] Q30_C1 = 64'd1686629713;
   localparam logic [63:0] Q30_C3 = 64'd693598668;
   localparam logic [63:0] Q30_C5 = 64'd85569306;
   localparam logic [63:0] Q30_C7 = 64'd5026995;
   localparam logic [63:0] Q30_C9 = 64'd172272;

   typedef logic [SINE_MAG_W-1:0] qsine_table_type [QSINE_DEPTH];

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  numerator;
      logic [DEN_W:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

   // sin(pi/2 * x) for x in Q16, rounded to Q15 and clamped.
   function automatic logic [SINE_MAG_W-1:0] quarter_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] r;
      x2 = (x * x) >> 16;
      p  = Q30_C9;
      p  = Q30_C7 - ((x2 * p) >> 16);
      p  = Q30_C5 - ((x2 * p) >> 16);
      p  = Q30_C3 - ((x2 * p) >> 16);
      p  = Q30_C1 - ((x2 * p) >> 16);
      r  = (x * p) >> 16;
      r  = (r + (64'd1 << 14)) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[SINE_MAG_W-1:0];
   endfunction

   function automatic qsine_table_type build_qsine();
      qsine_table_type t;
      for (int m = 0; m < QSINE_DEPTH; m++) begin
         t[m] = quarter_sine(64'(m) << (18 - SINE_TABLE_BITS));
      end
      return t;
   endfunction

endpackage

@@ src/oda_channels.sv @@
// Handshake channel interfaces for the request, result and register ports.
// Depends on oda_pkg for the payload widths.
interface oda_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [oda_pkg::SAMPLE_COUNT_W-1:0]   sample_count;
   logic                                 restart;
   modport source  (output valid, sample_count, restart, input ready);
   modport sink    (input valid, sample_count, restart, output ready);
   modport monitor (input valid, ready, sample_count, restart);
endinterface

interface oda_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [oda_pkg::SAMPLE_W-1:0]  sample;
   logic                                 last;
   modport source  (output valid, sample, last, input ready);
   modport sink    (input valid, sample, last, output ready);
   modport monitor (input valid, ready, sample, last);
endinterface

interface oda_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [oda_pkg::CSR_IDX_W-1:0]        index;
   logic [oda_pkg::CSR_DATA_W-1:0]       data;
   modport source  (output valid, index, data, input ready);
   modport sink    (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

@@ src/oda_sine_rom.sv @@
// Registered sine lookup from a quarter-wave constant table with mirroring.
// Depends on oda_pkg for the table builder and widths.
module oda_sine_rom (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic [oda_pkg::SINE_TABLE_BITS-1:0]  phase,
   output logic signed [oda_pkg::SAMPLE_W-1:0]  value
);
   import oda_pkg::*;

   localparam qsine_table_type QSINE = build_qsine();

   logic [1:0]                   quad;
   logic [SINE_TABLE_BITS-3:0]   pos;
   logic [QIDX_W-1:0]            qidx;
   logic [SINE_MAG_W-1:0]        mag;
   logic signed [SAMPLE_W-1:0]   value_in;
   logic signed [SAMPLE_W-1:0]   value_ff;

   always_comb begin
      quad = phase[SINE_TABLE_BITS-1 -: 2];
      pos  = phase[SINE_TABLE_BITS-3:0];
      if (quad[0]) begin
         qidx = QIDX_W'(QSINE_DEPTH - 1) - QIDX_W'(pos);
      end else begin
         qidx = QIDX_W'(pos);
      end
      mag = QSINE[qidx];
      if (quad[1]) begin
         value_in = -$signed({1'b0, mag});
      end else begin
         value_in = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

@@ src/oda_divider.sv @@
// Restoring divider that finds one quotient bit per cycle.
// Depends on oda_pkg for the request and response structs.
module oda_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  oda_pkg::div_req_type  req,
   output oda_pkg::div_rsp_type  rsp
);
   import oda_pkg::*;

   localparam int STEP_W = $clog2(QUOT_W + 1);

   logic [STEP_W-1:0]   step_ff, step_in;
   logic                done_ff, done_in;
   logic [DEN_W:0]      rem_ff, rem_in;
   logic [QUOT_W-1:0]   qsr_ff, qsr_in;
   logic [DEN_W:0]      div_ff, div_in;
   logic [DEN_W+1:0]    trial;

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      qsr_in  = qsr_ff;
      div_in  = div_ff;
      trial   = {rem_ff, qsr_ff[QUOT_W-1]} - {1'b0, div_ff};
      if (req.start) begin
         rem_in  = (DEN_W + 1)'(req.numerator[NUM_W-1:QUOT_W]);
         qsr_in  = req.numerator[QUOT_W-1:0];
         div_in  = req.divisor;
         step_in = STEP_W'(QUOT_W);
      end else if (step_ff != '0) begin
         if (!trial[DEN_W+1]) begin
            rem_in = trial[DEN_W:0];
         end else begin
            rem_in = {rem_ff[DEN_W-1:0], qsr_ff[QUOT_W-1]};
         end
         qsr_in  = {qsr_ff[QUOT_W-2:0], ~trial[DEN_W+1]};
         step_in = step_ff - 1'b1;
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      qsr_ff <= qsr_in;
      div_ff <= div_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = qsr_ff;

endmodule

@@ src/octave_down_additive_oscillator.sv @@
// Top level of the octave-down additive sine oscillator.
// Depends on oda_pkg, oda_channels, oda_sine_rom and oda_divider.
//
//   channel   direction   payload                      transfer
//   req_ch    in          sample_count, restart        valid & ready
//   rsp_ch    out         sample, last                 valid & ready
//   csr_ch    in          index, data                  valid & ready
//
// Each sample makes one table lookup per partial through the shared sine
// table, then 17 steps of the bit-serial divider. A request of n samples
// keeps req_ch.ready low until its last sample enters the output register.
// A stalled result holds in the output register while the next sample
// is computed. Reset is synchronous and restores the register defaults.
module octave_down_additive_oscillator (
   input  logic       clock,
   input  logic       reset,
   oda_req_if.sink    req_ch,
   oda_rsp_if.source  rsp_ch,
   oda_csr_if.sink    csr_ch
);
   import oda_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_PART   = 3'd2;
   localparam logic [2:0] ST_ABS    = 3'd3;
   localparam logic [2:0] ST_DSTART = 3'd4;
   localparam logic [2:0] ST_DWAIT  = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [PHASE_INC_W-1:0]    phase_inc_ff, phase_inc_in;
   logic [HCOUNT_W-1:0]       hcount_ff, hcount_in;
   logic                      falling_ff, falling_in;
   logic [RUN_W-1:0]          remain_ff, remain_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [ACC_W-1:0]          work_ff, work_in;
   logic [CNT_W-1:0]          issue_ff, issue_in;
   logic                      pend_ff, pend_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      neg_ff, neg_in;
   logic [QUOT_W-1:0]         quot_ff, quot_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      req_accept;
   logic                      issue;
   logic                      out_load;
   logic [RUN_W-1:0]          run_len;
   logic [CNT_W-1:0]          count_sel;
   logic [PHASE_INC_W-1:0]    inc;
   logic signed [SAMPLE_W-1:0] rom_value;
   logic signed [SUM_W-1:0]   sum_ext;
   logic [QUOT_W-1:0]         sat_mag;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   oda_sine_rom u_sine_rom (
      .clock  (clock),
      .enable (issue),
      .phase  (work_ff[PHASE_FRACTION_BITS-1 -: SINE_TABLE_BITS]),
      .value  (rom_value)
   );

   oda_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign inc          = phase_inc_ff >> (32 - PHASE_FRACTION_BITS);
   assign issue        = (state_ff == ST_PART) && (issue_ff != count_ff);
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign sum_ext      = SUM_W'(rom_value);

   assign div_req.start     = (state_ff == ST_DSTART);
   assign div_req.numerator = NUM_W'({sum_ff[MAG_W-1:0], 1'b0}) + NUM_W'(den_ff);
   assign div_req.divisor   = {den_ff, 1'b0};

   always_comb begin
      if (req_ch.sample_count > SAMPLE_COUNT_W'(MAX_RUN)) begin
         run_len = RUN_W'(MAX_RUN);
      end else begin
         run_len = RUN_W'(req_ch.sample_count);
      end
      if (hcount_ff == '0) begin
         count_sel = CNT_W'(1);
      end else if ({1'b0, hcount_ff} > (HCOUNT_W + 1)'(MAX_HARMONICS)) begin
         count_sel = CNT_W'(MAX_HARMONICS);
      end else begin
         count_sel = CNT_W'(hcount_ff);
      end
      if (neg_ff) begin
         sat_mag = (quot_ff > QUOT_W'(32768)) ? QUOT_W'(32768) : quot_ff;
         rsp_sample_in = SAMPLE_W'(-sat_mag);
      end else begin
         sat_mag = (quot_ff > QUOT_W'(32767)) ? QUOT_W'(32767) : quot_ff;
         rsp_sample_in = SAMPLE_W'(sat_mag);
      end
   end

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      phase_inc_in  = phase_inc_ff;
      hcount_in     = hcount_ff;
      falling_in    = falling_ff;
      remain_in     = remain_ff;
      count_in      = count_ff;
      den_in        = den_ff;
      work_in       = work_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      sum_in        = sum_ff;
      neg_in        = neg_ff;
      quot_in       = quot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_last_in   = rsp_last_ff;

      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            IDX_PHASE_INCREMENT: begin
               phase_inc_in = csr_ch.data;
            end
            IDX_HARMONIC_COUNT: begin
               hcount_in = csr_ch.data[HCOUNT_W-1:0];
            end
            IDX_FALLING_WEIGHTS: begin
               falling_in = csr_ch.data[0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_ch.restart) begin
                  acc_in = '0;
               end
               remain_in = run_len;
               count_in  = count_sel;
               if (falling_ff) begin
                  den_in = DEN_W'(((DEN_W + 1)'(1) << count_sel) - 1'b1);
               end else begin
                  den_in = DEN_W'(count_sel);
               end
               if (run_len != '0) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            work_in  = acc_ff;
            acc_in   = acc_ff + ACC_W'(inc);
            issue_in = '0;
            sum_in   = '0;
            state_in = ST_PART;
         end
         ST_PART: begin
            if (issue) begin
               work_in  = work_ff >> 1;
               issue_in = issue_ff + 1'b1;
            end
            pend_in = issue;
            if (pend_ff) begin
               if (falling_ff) begin
                  sum_in = (sum_ff <<< 1) + sum_ext;
               end else begin
                  sum_in = sum_ff + sum_ext;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            neg_in   = sum_ff[SUM_W-1];
            sum_in   = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_rsp.done) begin
               quot_in  = div_rsp.quotient;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (remain_ff == RUN_W'(1));
               remain_in    = remain_ff - 1'b1;
               state_in     = (remain_ff == RUN_W'(1)) ? ST_IDLE : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         phase_inc_ff <= PHASE_INC_RESET;
         hcount_ff    <= HCOUNT_RESET;
         falling_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         phase_inc_ff <= phase_inc_in;
         hcount_ff    <= hcount_in;
         falling_ff   <= falling_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      remain_ff <= remain_in;
      count_ff  <= count_in;
      den_ff    <= den_in;
      work_ff   <= work_in;
      issue_ff  <= issue_in;
      sum_ff    <= sum_in;
      neg_ff    <= neg_in;
      quot_ff   <= quot_in;
      rsp_last_ff <= rsp_last_in;
      if (out_load) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample = rsp_sample_ff;
   assign rsp_ch.last   = rsp_last_ff;

endmodule

@@ src/oda_checker.sv @@
// Port-level checks on the oscillator's request, result and register channels,
// bound to the top level. Depends on oda_pkg for the field widths.
module oda_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [oda_pkg::SAMPLE_COUNT_W-1:0]   req_sample_count,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [oda_pkg::SAMPLE_W-1:0]  rsp_sample,
   input logic                                 rsp_last,
   input logic                                 csr_valid,
   input logic                                 csr_ready
);

   // A request for at least one sample keeps the block busy afterwards.
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_sample_count != '0) |=> !req_ready)
      else $error("request accepted but block still ready");

   // While a sample that is not the last one waits, the run is unfinished.
   a_no_request_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request port ready in the middle of a run");

   // The block never refuses a register write.
   a_csr_always_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_sample) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind octave_down_additive_oscillator oda_checker u_oda_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_sample_count (req_ch.sample_count),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_sample       (rsp_ch.sample),
   .rsp_last         (rsp_ch.last),
   .csr_valid        (csr_ch.valid),
   .csr_ready        (csr_ch.ready)
);

@@ tb/octave_down_additive_oscillator_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the octave-down additive oscillator: it sends sample-run
// requests and register writes, predicts every sample and checks each result in order.
// Depends on oda_pkg, the oda channel interfaces and the oscillator top level.
module octave_down_additive_oscillator_tb;
   import oda_pkg::*;

   localparam int CYCLE_LIMIT   = 6_000_000;
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_PERCENT = 35;
   localparam int MAX_REPORTS   = 100;
   localparam int LUT_SIZE      = 1 << SINE_TABLE_BITS;
   localparam int QUARTER       = LUT_SIZE / 4;

   localparam logic [CSR_IDX_W-1:0] IDX_UNUSED = 2'd3;

   localparam logic [63:0] SIN_K1 = 64'd1686629713;
   localparam logic [63:0] SIN_K3 = 64'd693598668;
   localparam logic [63:0] SIN_K5 = 64'd85569306;
   localparam logic [63:0] SIN_K7 = 64'd5026995;
   localparam logic [63:0] SIN_K9 = 64'd172272;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } audio_sample_type;

   logic clock;
   logic reset;

   oda_req_if req_bus ();
   oda_rsp_if rsp_bus ();
   oda_csr_if csr_bus ();

   octave_down_additive_oscillator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   logic [PHASE_INC_W-1:0] cfg_phase_inc;
   logic [HCOUNT_W-1:0]    cfg_harmonics;
   logic                   cfg_falling;
   logic [ACC_W-1:0]       model_phase;

   int               sine_lut [LUT_SIZE];
   audio_sample_type pending_samples [$];
   int               error_count = 0;
   int               cycle_count = 0;
   bit               no_stall = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : fill_sine_lut
      logic [63:0] x;
      logic [63:0] xx;
      logic [63:0] poly;
      logic [63:0] r;
      for (int k = 0; k < LUT_SIZE; k++) begin
         x = 64'(k % QUARTER) << (18 - SINE_TABLE_BITS);
         if (((k / QUARTER) % 2) != 0) begin
            x = 64'd65536 - x;
         end
         xx   = (x * x) >> 16;
         poly = SIN_K9;
         poly = SIN_K7 - ((xx * poly) >> 16);
         poly = SIN_K5 - ((xx * poly) >> 16);
         poly = SIN_K3 - ((xx * poly) >> 16);
         poly = SIN_K1 - ((xx * poly) >> 16);
         r    = (x * poly) >> 16;
         r    = (r + 64'd16384) >> 15;
         if (r > 64'd32767) begin
            r = 64'd32767;
         end
         sine_lut[k] = (k >= 2 * QUARTER) ? -int'(r) : int'(r);
      end
   end

   function automatic logic [SAMPLE_W-1:0] mix_sample(input logic [ACC_W-1:0] phase,
                                                      input int count, input bit falling);
      longint      total;
      longint      den;
      longint      mag;
      longint      q;
      longint      partial;
      logic [63:0] frac;
      total = 0;
      for (int j = 0; j < count; j++) begin
         frac    = (64'(phase) >> j) & ((64'd1 << PHASE_FRACTION_BITS) - 64'd1);
         partial = sine_lut[frac >> (PHASE_FRACTION_BITS - SINE_TABLE_BITS)];
         if (falling) begin
            partial = partial * (longint'(1) << (count - 1 - j));
         end
         total += partial;
      end
      den = falling ? ((longint'(1) << count) - 1) : longint'(count);
      mag = (total < 0) ? -total : total;
      q   = (2 * mag + den) / (2 * den);
      if (total < 0) begin
         if (q > 32768) begin
            q = 32768;
         end
         q = -q;
      end else if (q > 32767) begin
         q = 32767;
      end
      return q[SAMPLE_W-1:0];
   endfunction

   function automatic void queue_run(input logic [SAMPLE_COUNT_W-1:0] count_in,
                                     input logic restart);
      int               n;
      int               partials;
      logic [ACC_W-1:0] step;
      audio_sample_type s;
      if (restart) begin
         model_phase = '0;
      end
      n        = (count_in > MAX_RUN) ? MAX_RUN : int'(count_in);
      partials = (cfg_harmonics == 0) ? 1 :
                 ((cfg_harmonics > MAX_HARMONICS) ? MAX_HARMONICS : int'(cfg_harmonics));
      step     = ACC_W'(cfg_phase_inc >> (32 - PHASE_FRACTION_BITS));
      for (int i = 0; i < n; i++) begin
         s.sample = mix_sample(model_phase, partials, cfg_falling);
         s.last   = (i == n - 1);
         pending_samples.push_back(s);
         model_phase = model_phase + step;
      end
   endfunction

   function automatic logic [SAMPLE_COUNT_W-1:0] random_run_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 2) begin
         return '0;
      end else if (pick < 72) begin
         return SAMPLE_COUNT_W'($urandom_range(1, 8));
      end else if (pick < 92) begin
         return SAMPLE_COUNT_W'($urandom_range(9, 40));
      end else if (pick < 97) begin
         return SAMPLE_COUNT_W'($urandom_range(41, 64));
      end
      return SAMPLE_COUNT_W'($urandom_range(65, 127));
   endfunction

   task automatic send_request(input logic [SAMPLE_COUNT_W-1:0] count_in,
                               input logic restart);
      if (!no_stall) begin
         while ($urandom_range(99) < STALL_PERCENT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid        <= 1'b1;
      req_bus.sample_count <= count_in;
      req_bus.restart      <= restart;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      queue_run(count_in, restart);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      case (idx)
         IDX_PHASE_INCREMENT: begin
            cfg_phase_inc = value;
         end
         IDX_HARMONIC_COUNT: begin
            cfg_harmonics = value[HCOUNT_W-1:0];
         end
         IDX_FALLING_WEIGHTS: begin
            cfg_falling = value[0];
         end
         default: begin
         end
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      while (pending_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_request(7'd1, 1'b1);
      send_request(7'd3, 1'b0);
      send_request(7'd0, 1'b0);
      send_request(7'd2, 1'b0);
      send_request(7'd0, 1'b1);
      send_request(7'd1, 1'b0);
   endtask

   task automatic test_register_extremes();
      drain_pipeline();
      write_register(IDX_PHASE_INCREMENT, 32'h8000_0000);
      write_register(IDX_HARMONIC_COUNT, 32'd16);
      write_register(IDX_FALLING_WEIGHTS, 32'd1);
      send_request(7'd64, 1'b1);
      send_request(7'd127, 1'b0);
      drain_pipeline();
      write_register(IDX_PHASE_INCREMENT, 32'h0000_0000);
      write_register(IDX_HARMONIC_COUNT, 32'd0);
      write_register(IDX_FALLING_WEIGHTS, 32'd0);
      send_request(7'd4, 1'b1);
      drain_pipeline();
      write_register(IDX_PHASE_INCREMENT, 32'hFFFF_FFFF);
      write_register(IDX_HARMONIC_COUNT, 32'hFFFF_FFFF);
      write_register(IDX_FALLING_WEIGHTS, 32'hFFFF_FFFE);
      write_register(IDX_UNUSED, $urandom);
      send_request(7'd65, 1'b1);
      send_request(7'd5, 1'b0);
      drain_pipeline();
      write_register(IDX_PHASE_INCREMENT, 32'h7FFF_FFFF);
      write_register(IDX_HARMONIC_COUNT, 32'd2);
      write_register(IDX_FALLING_WEIGHTS, 32'd1);
      send_request(7'd8, 1'b1);
      send_request(7'd1, 1'b0);
   endtask

   task automatic test_random_settings();
      logic [31:0] value;
      for (int phase = 0; phase < 12; phase++) begin
         drain_pipeline();
         case ($urandom_range(3))
            0: value = $urandom;
            1: value = $urandom_range(1 << 20);
            2: value = 32'h8000_0000 - $urandom_range(255);
            default: value = $urandom >> $urandom_range(31);
         endcase
         write_register(IDX_PHASE_INCREMENT, value);
         value = $urandom;
         value[HCOUNT_W-1:0] = ($urandom_range(9) == 0) ? HCOUNT_W'($urandom_range(31))
                                                        : HCOUNT_W'($urandom_range(1, 16));
         write_register(IDX_HARMONIC_COUNT, value);
         write_register(IDX_FALLING_WEIGHTS, $urandom);
         if ($urandom_range(3) == 0) begin
            write_register(IDX_UNUSED, $urandom);
         end
         for (int n = 0; n < 35; n++) begin
            send_request(random_run_length(), ($urandom_range(4) == 0));
         end
      end
   endtask

   task automatic test_back_to_back();
      no_stall = 1'b1;
      for (int n = 0; n < 30; n++) begin
         send_request(random_run_length(), ($urandom_range(5) == 0));
      end
      drain_pipeline();
      no_stall = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= no_stall || ($urandom_range(99) >= STALL_PERCENT);
   end

   always @(posedge clock) begin : check_results
      audio_sample_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_samples.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: unexpected sample, expected none, actual %0d last %0b",
                        $time, rsp_bus.sample, rsp_bus.last);
            end
         end else begin
            want = pending_samples.pop_front();
            if (rsp_bus.sample !== want.sample) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: sample mismatch, expected %0d actual %0d",
                           $time, want.sample, rsp_bus.sample);
               end
            end
            if (rsp_bus.last !== want.last) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: last mismatch, expected %0b actual %0b",
                           $time, want.last, rsp_bus.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** octave_down_additive_oscillator: FAILED **");
         $finish;
      end
   end

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.sample_count <= '0;
      req_bus.restart      <= 1'b0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= '0;
      csr_bus.data         <= '0;
      cfg_phase_inc         = PHASE_INC_RESET;
      cfg_harmonics         = HCOUNT_RESET;
      cfg_falling           = 1'b0;
      model_phase           = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_random_settings();
      test_back_to_back();

      drain_pipeline();
      if (error_count == 0) begin
         $display("** octave_down_additive_oscillator: PASSED **");
      end else begin
         $display("** octave_down_additive_oscillator: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/oda_pkg.sv
src/oda_channels.sv
src/oda_sine_rom.sv
src/oda_divider.sv
src/octave_down_additive_oscillator.sv
src/oda_checker.sv
tb/octave_down_additive_oscillator_tb.sv
